### src/dcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_pkg: shared types and constants of the detection candidate filter
// Field widths, register codes, element kinds and the item that travels
// from the front end through the queue into the back end.
// ----------------------------------------------------------------------------
package dcf_pkg;

  localparam int VALUE_W    = 32;
  localparam int THR_W      = 17;
  localparam int NCLS_W     = 8;
  localparam int POS_W      = 8;
  localparam int CLASS_W    = 7;
  localparam int BOX_XY_W   = 17;
  localparam int BOX_WH_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam int KIND_W     = 3;

  localparam int QUEUE_DEPTH     = 4;
  localparam int DEF_MAX_CLASSES = 128;
  localparam int DEF_FRAC_BITS   = 16;
  // Class index field holds at most this many classes
  localparam int CLASS_LIMIT     = 128;

  localparam logic [THR_W-1:0]  THR_RESET  = 17'd16384;
  localparam logic [NCLS_W-1:0] NCLS_RESET = 8'd80;

  // Box and objectness elements ahead of the class scores in every anchor
  localparam logic [POS_W-1:0] HEADER_LEN = 8'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLASSES = 1'd1;

  // Element kinds within an anchor
  localparam logic [KIND_W-1:0] KIND_CX  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CY  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_W_  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_H   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_OBJ = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLS = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [CLASS_W-1:0]        cls;
    logic                      first;       // class 0 of the anchor
    logic                      anchor_end;  // last class element of the anchor
    logic                      above;       // objectness over threshold
    logic signed [VALUE_W-1:0] value;
  } dcf_item_t;

endpackage

### src/detection_candidate_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_candidate_filter: detector output decode, one element per cycle
// Input channel (in_valid/in_stall): one fixed-point tensor element per
// transfer, in_tensor_last on the final element of the tensor. Every anchor
// is center x, center y, width, height, objectness, then num_classes scores.
// Result channel (out_valid/out_stall): one corner box, best class and its
// confidence for each complete anchor whose objectness beats the threshold.
// Throughput is one element per cycle while in_stall is low; the score path
// has a single 32x32 multiplier and a single compare per element.
// The result is registered: an anchor's last class score passes the queue,
// the multiply stage, the scale stage and the result register.
// A 4-entry queue decouples the input from the scoring pipe. While a result
// is stalled the pipe holds and the queue keeps taking transfers; in_stall
// rises only once the queue is full.
// Configuration (cfg_we/cfg_index/cfg_wdata) must be written only while idle;
// the block does not enforce it. Reset clears the position counter, the queue
// and the result valid, and restores the default threshold and class count.
// ----------------------------------------------------------------------------
module detection_candidate_filter #(
  parameter int MAX_CLASSES         = dcf_pkg::DEF_MAX_CLASSES,
  parameter int VALUE_FRACTION_BITS = dcf_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [dcf_pkg::VALUE_W-1:0]  in_value,
  input  logic                                in_tensor_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dcf_pkg::BOX_XY_W-1:0] out_box_x,
  output logic signed [dcf_pkg::BOX_XY_W-1:0] out_box_y,
  output logic signed [dcf_pkg::BOX_WH_W-1:0] out_box_w,
  output logic signed [dcf_pkg::BOX_WH_W-1:0] out_box_h,
  output logic [dcf_pkg::CLASS_W-1:0]         out_class_index,
  output logic signed [dcf_pkg::VALUE_W-1:0]  out_confidence,
  input  logic                                cfg_we,
  input  logic [dcf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dcf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import dcf_pkg::*;

  logic      q_push, q_full, q_pop, q_valid;
  dcf_item_t q_in, q_out;

  dcf_front #(
    .MAX_CLASSES (MAX_CLASSES),
    .FRAC_BITS   (VALUE_FRACTION_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_tensor_last (in_tensor_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_in)
  );

  dcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .item_in   (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .item_out  (q_out)
  );

  dcf_back #(
    .FRAC_BITS (VALUE_FRACTION_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_out),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_box_x       (out_box_x),
    .out_box_y       (out_box_y),
    .out_box_w       (out_box_w),
    .out_box_h       (out_box_h),
    .out_class_index (out_class_index),
    .out_confidence  (out_confidence)
  );

endmodule

### src/dcf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_front: input side of the detection candidate filter
// Holds the configuration registers, tracks the element position within the
// anchor, tags each transfer with its kind and pushes it into the queue.
// ----------------------------------------------------------------------------
module dcf_front #(
  parameter int MAX_CLASSES = dcf_pkg::DEF_MAX_CLASSES,
  parameter int FRAC_BITS   = dcf_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [dcf_pkg::VALUE_W-1:0] in_value,
  input  logic                              in_tensor_last,
  input  logic                              cfg_we,
  input  logic [dcf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dcf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              q_full,
  output logic                              q_push,
  output dcf_pkg::dcf_item_t                q_item
);
  import dcf_pkg::*;

  localparam int CAP    = (MAX_CLASSES < CLASS_LIMIT) ? MAX_CLASSES : CLASS_LIMIT;
  localparam int SA_L   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int SA_R   = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int CMP_W  = VALUE_W + SA_L + 2;
  localparam logic [NCLS_W-1:0] CAP_N = NCLS_W'(CAP);

  logic [THR_W-1:0]  thr_r;
  logic [NCLS_W-1:0] ncls_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [NCLS_W-1:0] eff_cls;
  logic [POS_W-1:0]  last_pos;
  logic              is_cls;
  logic              anchor_end;
  logic signed [CMP_W-1:0] obj_cmp, thr_cmp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      ncls_r <= NCLS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD:   thr_r  <= cfg_wdata[THR_W-1:0];
        CFG_NUM_CLASSES: ncls_r <= cfg_wdata[NCLS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the class count to 1..CAP
  always_comb begin
    if (ncls_r == '0) begin
      eff_cls = NCLS_W'(1);
    end else if (ncls_r > CAP_N) begin
      eff_cls = CAP_N;
    end else begin
      eff_cls = ncls_r;
    end
  end

  assign last_pos   = POS_W'(eff_cls) + HEADER_LEN - POS_W'(1);
  assign is_cls     = (pos_r >= HEADER_LEN);
  assign anchor_end = is_cls && (pos_r >= last_pos);

  // Align objectness and threshold to a common fraction before comparing
  assign obj_cmp = CMP_W'(in_value) <<< SA_L;
  assign thr_cmp = $signed(CMP_W'(thr_r) << SA_R);

  always_comb begin
    q_item            = '0;
    q_item.value      = in_value;
    q_item.cls        = CLASS_W'(pos_r - HEADER_LEN);
    q_item.first      = (pos_r == HEADER_LEN);
    q_item.anchor_end = anchor_end;
    q_item.above      = (obj_cmp > thr_cmp);
    unique case (pos_r)
      8'd0:    q_item.kind = KIND_CX;
      8'd1:    q_item.kind = KIND_CY;
      8'd2:    q_item.kind = KIND_W_;
      8'd3:    q_item.kind = KIND_H;
      8'd4:    q_item.kind = KIND_OBJ;
      default: q_item.kind = KIND_CLS;
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Restart at the anchor end and after the last tensor element
  always_comb begin
    if (in_tensor_last || anchor_end) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (q_push) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

### src/dcf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_queue: short item queue between front and back end
// A small circular buffer; lets the front keep taking transfers while the
// back end waits on the result channel.
// ----------------------------------------------------------------------------
module dcf_queue #(
  parameter int DEPTH = dcf_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dcf_pkg::dcf_item_t item_in,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output dcf_pkg::dcf_item_t item_out
);
  import dcf_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  dcf_item_t          slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign item_out  = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

### src/dcf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_back: scoring and result side of the detection candidate filter
// Multiply stage, scale/saturate stage, then box capture, running argmax and
// the result register. The whole pipe holds while a result waits.
// ----------------------------------------------------------------------------
module dcf_back #(
  parameter int FRAC_BITS = dcf_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  dcf_pkg::dcf_item_t                  q_item,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dcf_pkg::BOX_XY_W-1:0] out_box_x,
  output logic signed [dcf_pkg::BOX_XY_W-1:0] out_box_y,
  output logic signed [dcf_pkg::BOX_WH_W-1:0] out_box_w,
  output logic signed [dcf_pkg::BOX_WH_W-1:0] out_box_h,
  output logic [dcf_pkg::CLASS_W-1:0]         out_class_index,
  output logic signed [dcf_pkg::VALUE_W-1:0]  out_confidence
);
  import dcf_pkg::*;

  localparam int PROD_W = 2 * VALUE_W;
  localparam int SUM_W  = VALUE_W + 2;
  localparam logic signed [PROD_W-1:0]  PROD_BIAS = (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);
  localparam logic signed [SUM_W-1:0]   XY_BIAS   = (SUM_W'(1) << (FRAC_BITS + 1)) - SUM_W'(1);
  localparam logic signed [VALUE_W-1:0] WH_BIAS   = (VALUE_W'(1) << FRAC_BITS) - VALUE_W'(1);

  logic advance;

  // Multiply stage
  logic                      m_vld_r;
  dcf_item_t                 m_item_r;
  logic signed [PROD_W-1:0]  m_prod_r, m_prod_nxt;
  logic signed [VALUE_W-1:0] obj_r;

  // Scale stage
  logic                      s_vld_r;
  dcf_item_t                 s_item_r;
  logic signed [VALUE_W-1:0] s_scaled_r, s_scaled_nxt;
  logic signed [PROD_W-1:0]  prod_adj, prod_q;

  // Anchor state
  logic signed [VALUE_W-1:0] cx_r, cy_r, w_r, h_r;
  logic                      kept_r;
  logic signed [VALUE_W-1:0] best_score_r, best_score_nxt;
  logic [CLASS_W-1:0]        best_class_r, best_class_nxt;
  logic                      take, emit;

  // Box arithmetic
  logic signed [SUM_W-1:0]   dx, dy, dx_adj, dy_adj, qx, qy;
  logic signed [VALUE_W-1:0] w_adj, h_adj, qw, qh;
  logic signed [BOX_XY_W-1:0] box_x, box_y;
  logic signed [BOX_WH_W-1:0] box_w, box_h;

  // Result register
  logic                       out_valid_r;
  logic signed [BOX_XY_W-1:0] out_box_x_r, out_box_y_r;
  logic signed [BOX_WH_W-1:0] out_box_w_r, out_box_h_r;
  logic [CLASS_W-1:0]         out_class_r;
  logic signed [VALUE_W-1:0]  out_conf_r;

  assign advance = !(out_valid_r && out_stall);
  assign q_pop   = q_valid && advance;

  assign m_prod_nxt = obj_r * q_item.value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
    end else if (advance) begin
      m_vld_r <= q_valid;
      s_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_item_r   <= q_item;
      m_prod_r   <= m_prod_nxt;
      s_item_r   <= m_item_r;
      s_scaled_r <= s_scaled_nxt;
    end
    // Latch objectness as it leaves the queue so the following scores use it
    if (q_pop && q_item.kind == KIND_OBJ) begin
      obj_r <= q_item.value;
    end
  end

  // Truncate toward zero, then saturate to the value width
  assign prod_adj = m_prod_r[PROD_W-1] ? m_prod_r + PROD_BIAS : m_prod_r;
  assign prod_q   = prod_adj >>> FRAC_BITS;
  always_comb begin
    if ((&prod_q[PROD_W-1:VALUE_W-1]) || !(|prod_q[PROD_W-1:VALUE_W-1])) begin
      s_scaled_nxt = prod_q[VALUE_W-1:0];
    end else begin
      s_scaled_nxt = {prod_q[PROD_W-1], {(VALUE_W-1){~prod_q[PROD_W-1]}}};
    end
  end

  // Running argmax, lowest class wins ties
  assign take           = s_item_r.first || (s_scaled_r > best_score_r);
  assign best_score_nxt = take ? s_scaled_r : best_score_r;
  assign best_class_nxt = take ? s_item_r.cls : best_class_r;

  assign emit = s_vld_r && advance && (s_item_r.kind == KIND_CLS)
                && s_item_r.anchor_end && kept_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r <= 1'b0;
    end else if (s_vld_r && advance && s_item_r.kind == KIND_OBJ) begin
      kept_r <= s_item_r.above;
    end
  end

  always_ff @(posedge clk) begin
    if (s_vld_r && advance) begin
      unique case (s_item_r.kind)
        KIND_CX:  cx_r <= s_item_r.value;
        KIND_CY:  cy_r <= s_item_r.value;
        KIND_W_:  w_r  <= s_item_r.value;
        KIND_H:   h_r  <= s_item_r.value;
        KIND_OBJ: ;
        KIND_CLS: begin
          best_score_r <= best_score_nxt;
          best_class_r <= best_class_nxt;
        end
        default: ;
      endcase
    end
  end

  // Corner box: (2c - size) / 2, truncated toward zero
  assign dx     = (SUM_W'(cx_r) <<< 1) - SUM_W'(w_r);
  assign dy     = (SUM_W'(cy_r) <<< 1) - SUM_W'(h_r);
  assign dx_adj = dx[SUM_W-1] ? dx + XY_BIAS : dx;
  assign dy_adj = dy[SUM_W-1] ? dy + XY_BIAS : dy;
  assign qx     = dx_adj >>> (FRAC_BITS + 1);
  assign qy     = dy_adj >>> (FRAC_BITS + 1);
  assign w_adj  = w_r[VALUE_W-1] ? w_r + WH_BIAS : w_r;
  assign h_adj  = h_r[VALUE_W-1] ? h_r + WH_BIAS : h_r;
  assign qw     = w_adj >>> FRAC_BITS;
  assign qh     = h_adj >>> FRAC_BITS;

  always_comb begin
    if ((&qx[SUM_W-1:BOX_XY_W-1]) || !(|qx[SUM_W-1:BOX_XY_W-1])) begin
      box_x = qx[BOX_XY_W-1:0];
    end else begin
      box_x = {qx[SUM_W-1], {(BOX_XY_W-1){~qx[SUM_W-1]}}};
    end
    if ((&qy[SUM_W-1:BOX_XY_W-1]) || !(|qy[SUM_W-1:BOX_XY_W-1])) begin
      box_y = qy[BOX_XY_W-1:0];
    end else begin
      box_y = {qy[SUM_W-1], {(BOX_XY_W-1){~qy[SUM_W-1]}}};
    end
    if ((&qw[VALUE_W-1:BOX_WH_W-1]) || !(|qw[VALUE_W-1:BOX_WH_W-1])) begin
      box_w = qw[BOX_WH_W-1:0];
    end else begin
      box_w = {qw[VALUE_W-1], {(BOX_WH_W-1){~qw[VALUE_W-1]}}};
    end
    if ((&qh[VALUE_W-1:BOX_WH_W-1]) || !(|qh[VALUE_W-1:BOX_WH_W-1])) begin
      box_h = qh[BOX_WH_W-1:0];
    end else begin
      box_h = {qh[VALUE_W-1], {(BOX_WH_W-1){~qh[VALUE_W-1]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_box_x_r <= box_x;
      out_box_y_r <= box_y;
      out_box_w_r <= box_w;
      out_box_h_r <= box_h;
      out_class_r <= best_class_nxt;
      out_conf_r  <= best_score_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_box_x       = out_box_x_r;
  assign out_box_y       = out_box_y_r;
  assign out_box_w       = out_box_w_r;
  assign out_box_h       = out_box_h_r;
  assign out_class_index = out_class_r;
  assign out_confidence  = out_conf_r;

endmodule

### src/dcf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_checker: port-level checks for the detection candidate filter
// Watches reset, result hold under stall and the cause of input stall.
// ----------------------------------------------------------------------------
module dcf_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [dcf_pkg::BOX_XY_W-1:0] out_box_x,
  input logic [dcf_pkg::CLASS_W-1:0]         out_class_index,
  input logic signed [dcf_pkg::VALUE_W-1:0]  out_confidence
);

  // Reset empties the queue and drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall present after reset");

  // A stalled result stays put
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_confidence)
                               && $stable(out_class_index) && $stable(out_box_x))
    else $error("stalled result changed");

  // The queue only fills while a result was being held back
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without a held result");

endmodule

bind detection_candidate_filter dcf_checker u_dcf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_box_x       (out_box_x),
  .out_class_index (out_class_index),
  .out_confidence  (out_confidence)
);
